FILE: src/difs_pkg.sv
// ----------------------------------------------------------------------------
// difs_pkg: shared types and constants for the dual igniter fire sequencer
// Transaction payloads, mode and status codes, register indexes, phase states.
// ----------------------------------------------------------------------------
package difs_pkg;

	localparam int unsigned CfgW = 16;
	localparam int unsigned CntW = 16;

	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_IGNITE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	localparam logic [1:0] ST_ACTIVE  = 2'd0;
	localparam logic [1:0] ST_OPEN    = 2'd1;
	localparam logic [1:0] ST_READY   = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	localparam logic [1:0] CFG_OPEN_THRESHOLD   = 2'd0;
	localparam logic [1:0] CFG_CLOSED_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_FIRE_TICKS       = 2'd2;
	localparam logic [1:0] CFG_CHARGE_TICKS     = 2'd3;

	localparam logic signed [CfgW-1:0] OPEN_THRESHOLD_RST   = 16'sd100;
	localparam logic signed [CfgW-1:0] CLOSED_THRESHOLD_RST = 16'sd20000;
	localparam logic [CfgW-1:0]        FIRE_TICKS_RST       = 16'd5;
	localparam logic [CfgW-1:0]        CHARGE_TICKS_RST     = 16'd20;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_FIRE   = 2'd1,
		PH_CHARGE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              channel;
		logic signed [15:0] sense_drogue;
		logic signed [15:0] sense_main;
	} difs_in_t;

	typedef struct packed {
		logic       drive_drogue;
		logic       drive_main;
		logic       status_valid;
		logic [1:0] status_code;
		logic       fired_drogue;
		logic       fired_main;
	} difs_out_t;

endpackage

FILE: src/dual_igniter_fire_sequencer.sv
// ----------------------------------------------------------------------------
// dual_igniter_fire_sequencer: drogue and main pyro channel sequencer
// Input register, sequencer core and result register with valid/ready flow.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while the output side is not stalled and
// returns exactly one result for each, in order. A transaction is held in the
// input register, processed combinationally against the sequencer state, and
// its result is captured in the output register. Configuration registers
// (open_threshold, closed_threshold, fire_ticks, charge_ticks) reset to 100,
// 20000, 5 and 20 and are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while no transaction is in flight, which the block
// itself does not enforce.
module dual_igniter_fire_sequencer
	import difs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [CfgW-1:0] cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  difs_in_t        in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output difs_out_t       out_data
);

	difs_in_t  item_s1;
	logic      valid_s1;
	difs_out_t result;
	difs_out_t out_q;
	logic      out_valid_q;
	logic      adv;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	difs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (adv),
		.item      (item_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: src/difs_core.sv
// ----------------------------------------------------------------------------
// difs_core: sequencer state and per-transaction update
// Holds configuration, request and fired flags, the phase machine and the
// tick counter; computes the result of one transaction from the current state.
// ----------------------------------------------------------------------------
module difs_core
	import difs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [CfgW-1:0] cfg_data,
	input  logic            step,
	input  difs_in_t        item,
	output difs_out_t       result
);

	logic signed [CfgW-1:0] open_q;
	logic signed [CfgW-1:0] closed_q;
	logic [CfgW-1:0]        fire_q;
	logic [CfgW-1:0]        charge_q;

	logic [1:0]      req_q, req_d;
	logic [1:0]      fired_q, fired_d;
	phase_t          phase_q, phase_d, cur;
	logic            scan_q, scan_d;
	logic [CntW-1:0] cnt_q, cnt_d;

	logic [CntW:0]          cnt_inc;
	logic [CfgW-1:0]        fire_lim;
	logic signed [15:0]     scan_sense;
	logic signed [15:0]     query_sense;
	logic                   do_check;
	logic                   query_active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= OPEN_THRESHOLD_RST;
			closed_q <= CLOSED_THRESHOLD_RST;
			fire_q   <= FIRE_TICKS_RST;
			charge_q <= CHARGE_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OPEN_THRESHOLD:   open_q   <= cfg_data;
				CFG_CLOSED_THRESHOLD: closed_q <= cfg_data;
				CFG_FIRE_TICKS:       fire_q   <= cfg_data;
				CFG_CHARGE_TICKS:     charge_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (phase_q)
			PH_FIRE:   cur = PH_FIRE;
			PH_CHARGE: cur = PH_CHARGE;
			default:   cur = PH_IDLE;
		endcase
	end

	assign cnt_inc    = {1'b0, cnt_q} + {{CntW{1'b0}}, 1'b1};
	assign fire_lim   = (fire_q == '0) ? {{(CfgW-1){1'b0}}, 1'b1} : fire_q;
	assign scan_sense = scan_q ? item.sense_main : item.sense_drogue;

	// next state
	always_comb begin
		phase_d  = cur;
		scan_d   = scan_q;
		cnt_d    = cnt_q;
		req_d    = req_q;
		fired_d  = fired_q;
		do_check = 1'b0;
		unique case (item.mode)
			MODE_TICK: begin
				unique case (cur)
					PH_FIRE: begin
						if (cnt_inc >= {1'b0, fire_lim}) begin
							phase_d  = PH_CHARGE;
							cnt_d    = '0;
							do_check = (charge_q == '0);
						end else begin
							cnt_d = cnt_inc[CntW-1:0];
						end
					end
					PH_CHARGE: begin
						if (cnt_inc >= {1'b0, charge_q}) begin
							do_check = 1'b1;
						end else begin
							cnt_d = cnt_inc[CntW-1:0];
						end
					end
					default: ;
				endcase
			end
			MODE_IGNITE: begin
				req_d[item.channel] = 1'b1;
				if (cur == PH_IDLE) begin
					if (req_d[0] && !fired_q[0]) begin
						phase_d = PH_FIRE;
						scan_d  = 1'b0;
						cnt_d   = '0;
					end else if (req_d[1] && !fired_q[1]) begin
						phase_d = PH_FIRE;
						scan_d  = 1'b1;
						cnt_d   = '0;
					end
				end
			end
			default: ;
		endcase
		if (do_check) begin
			if (scan_sense < open_q) begin
				fired_d[scan_q] = 1'b1;
			end
			cnt_d = '0;
			if (!scan_q && req_q[1] && !fired_q[1]) begin
				phase_d = PH_FIRE;
				scan_d  = 1'b1;
			end else begin
				phase_d = PH_IDLE;
				scan_d  = 1'b0;
			end
		end
	end

	// outputs
	always_comb begin
		query_sense  = item.channel ? item.sense_main : item.sense_drogue;
		query_active = ((cur == PH_FIRE) && (scan_q == item.channel))
			|| (req_q[item.channel] && !fired_q[item.channel]);
		result.drive_drogue = (phase_d == PH_FIRE) && !scan_d;
		result.drive_main   = (phase_d == PH_FIRE) && scan_d;
		result.fired_drogue = fired_d[0];
		result.fired_main   = fired_d[1];
		result.status_valid = (item.mode == MODE_QUERY);
		result.status_code  = ST_ACTIVE;
		if (item.mode == MODE_QUERY && !query_active) begin
			priority if (query_sense < open_q) begin
				result.status_code = ST_OPEN;
			end else if (query_sense > closed_q) begin
				result.status_code = ST_READY;
			end else begin
				result.status_code = ST_UNKNOWN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			scan_q  <= 1'b0;
			cnt_q   <= '0;
			req_q   <= '0;
			fired_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			scan_q  <= scan_d;
			cnt_q   <= cnt_d;
			req_q   <= req_d;
			fired_q <= fired_d;
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (!scan_q && cnt_q == '0))
		else $error("idle sequencer holds a scan position or count");

	a_fire_eligible: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FIRE) |-> (req_q[scan_q] && !fired_q[scan_q]))
		else $error("firing a channel that is not requested or already fired");

	a_fired_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(fired_q[0]) && !$fell(fired_q[1]))
		else $error("fired flag cleared");

	a_one_drive: assert property (@(posedge clk) disable iff (!arst_n)
		!(result.drive_drogue && result.drive_main))
		else $error("both igniters driven");

endmodule

FILE: dv/dual_igniter_fire_sequencer_tb.sv
// ----------------------------------------------------------------------------
// dual_igniter_fire_sequencer_tb: self-checking testbench for the sequencer
// Drives directed and random transactions through the valid/ready input with
// random idling on both sides. A transaction-level copy of the sequencer predicts
// each result, which is compared field by field with what the block returns.
// Covers threshold and tick register extremes, retried scans, mid-phase
// register changes, input back-pressure and confirmation of both channels.
// ----------------------------------------------------------------------------
module dual_igniter_fire_sequencer_tb;
	import difs_pkg::*;

	localparam int         CycleLimit  = 400000;
	localparam int         DrainCycles = 4;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_we;
	logic [1:0]      cfg_index;
	logic [CfgW-1:0] cfg_data;
	logic            in_valid;
	logic            in_ready;
	difs_in_t        in_data;
	logic            out_valid;
	logic            out_ready = 1'b0;
	difs_out_t       out_data;

	dual_igniter_fire_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// sequencer copy used for prediction
	logic signed [15:0] open_thr   = OPEN_THRESHOLD_RST;
	logic signed [15:0] closed_thr = CLOSED_THRESHOLD_RST;
	logic [15:0]        fire_lim   = FIRE_TICKS_RST;
	logic [15:0]        charge_lim = CHARGE_TICKS_RST;
	logic [1:0]         req_flags    = '0;
	logic [1:0]         fired_flags  = '0;
	logic [1:0]         firing_flags = '0;
	phase_t             ph           = PH_IDLE;
	logic               scan_ch      = 1'b0;
	int unsigned        tick_cnt     = 0;

	difs_out_t expected_results[$];
	int        mismatch_count = 0;
	int        cycle_count    = 0;
	int        send_idle_pct  = 0;
	int        stall_pct      = 0;
	int        hold_cycles    = 0;

	function automatic logic ready_to_fire(logic ch);
		return req_flags[ch] && !fired_flags[ch];
	endfunction

	task automatic start_fire(logic ch);
		scan_ch      = ch;
		firing_flags = 2'b01 << ch;
		ph           = PH_FIRE;
		tick_cnt     = 0;
	endtask

	task automatic finish_check(difs_in_t it);
		logic signed [15:0] s;
		s = scan_ch ? it.sense_main : it.sense_drogue;
		if (s < open_thr)
			fired_flags[scan_ch] = 1'b1;
		tick_cnt = 0;
		if (!scan_ch && ready_to_fire(1'b1)) begin
			start_fire(1'b1);
		end else begin
			ph      = PH_IDLE;
			scan_ch = 1'b0;
		end
	endtask

	task automatic predict_outputs(difs_in_t it);
		difs_out_t          res;
		logic signed [15:0] s;
		int unsigned        next_cnt;
		res = '0;
		if (ph != PH_FIRE && ph != PH_CHARGE) begin
			ph           = PH_IDLE;
			firing_flags = '0;
		end
		case (it.mode)
			MODE_TICK: begin
				next_cnt = tick_cnt + 1;
				if (ph == PH_FIRE) begin
					if (next_cnt >= ((fire_lim == 0) ? 1 : fire_lim)) begin
						firing_flags = '0;
						tick_cnt     = 0;
						ph           = PH_CHARGE;
						if (charge_lim == 0)
							finish_check(it);
					end else begin
						tick_cnt = next_cnt;
					end
				end else if (ph == PH_CHARGE) begin
					if (next_cnt >= charge_lim)
						finish_check(it);
					else
						tick_cnt = next_cnt;
				end
			end
			MODE_IGNITE: begin
				req_flags[it.channel] = 1'b1;
				if (ph == PH_IDLE) begin
					if (ready_to_fire(1'b0))
						start_fire(1'b0);
					else if (ready_to_fire(1'b1))
						start_fire(1'b1);
				end
			end
			MODE_QUERY: begin
				res.status_valid = 1'b1;
				s = it.channel ? it.sense_main : it.sense_drogue;
				if (firing_flags[it.channel] || ready_to_fire(it.channel))
					res.status_code = ST_ACTIVE;
				else if (s < open_thr)
					res.status_code = ST_OPEN;
				else if (s > closed_thr)
					res.status_code = ST_READY;
				else
					res.status_code = ST_UNKNOWN;
			end
			default: ;
		endcase
		res.drive_drogue = (ph == PH_FIRE) && !scan_ch;
		res.drive_main   = (ph == PH_FIRE) && scan_ch;
		res.fired_drogue = fired_flags[0];
		res.fired_main   = fired_flags[1];
		expected_results.push_back(res);
	endtask

	function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		difs_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result expected none, got %p", $time, out_data);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("drive_drogue", want.drive_drogue, out_data.drive_drogue);
				check_field("drive_main", want.drive_main, out_data.drive_main);
				check_field("status_valid", want.status_valid, out_data.status_valid);
				check_field("status_code", want.status_code, out_data.status_code);
				check_field("fired_drogue", want.fired_drogue, out_data.fired_drogue);
				check_field("fired_main", want.fired_main, out_data.fired_main);
			end
		end
	end

	// hold off for a counted stretch, else stall at random
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready   <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_transaction(difs_in_t it);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predict_outputs(it);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_OPEN_THRESHOLD:   open_thr   = val;
			CFG_CLOSED_THRESHOLD: closed_thr = val;
			CFG_FIRE_TICKS:       fire_lim   = val;
			CFG_CHARGE_TICKS:     charge_lim = val;
			default: ;
		endcase
	endtask

	task automatic set_idling(int sel);
		case (sel)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 68; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 68; end
			default: begin send_idle_pct = 16; stall_pct = 16; end
		endcase
	endtask

	function automatic difs_in_t make_item(logic [1:0] m, logic ch, int sd, int sm);
		difs_in_t it;
		it.mode         = m;
		it.channel      = ch;
		it.sense_drogue = 16'(sd);
		it.sense_main   = 16'(sm);
		return it;
	endfunction

	function automatic logic signed [15:0] rand_sense();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return open_thr;
			3: return open_thr - 16'sd1;
			4: return closed_thr;
			5: return closed_thr + 16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	// sense at or above the open threshold, so a check leaves the channel unfired
	function automatic logic signed [15:0] safe_sense();
		int lo;
		lo = open_thr;
		return 16'(lo + int'($urandom_range(32767 - lo)));
	endfunction

	function automatic difs_in_t random_item(bit allow_ignite, logic [1:0] fire_mask);
		difs_in_t it;
		int       r;
		r               = $urandom_range(99);
		it.channel      = $urandom_range(1);
		it.sense_drogue = rand_sense();
		it.sense_main   = rand_sense();
		if (r < 50) begin
			it.mode = MODE_TICK;
			if (!fire_mask[0] && it.sense_drogue < open_thr)
				it.sense_drogue = safe_sense();
			if (!fire_mask[1] && it.sense_main < open_thr)
				it.sense_main = safe_sense();
		end else if (r < 62 && allow_ignite) begin
			it.mode = MODE_IGNITE;
		end else if (r < 95) begin
			it.mode = MODE_QUERY;
		end else begin
			it.mode = MODE_UNUSED;
		end
		return it;
	endfunction

	task automatic run_random(int count, bit allow_ignite, logic [1:0] fire_mask);
		repeat (count) send_transaction(random_item(allow_ignite, fire_mask));
		wait_for_drain();
	endtask

	task automatic test_reset_queries();
		set_idling(0);
		send_transaction(make_item(MODE_QUERY, 1'b0, -32768, 0));
		send_transaction(make_item(MODE_QUERY, 1'b1, 0, 32767));
		send_transaction(make_item(MODE_QUERY, 1'b0, 100, 0));
		send_transaction(make_item(MODE_QUERY, 1'b1, 0, 20001));
		send_transaction(make_item(MODE_QUERY, 1'b1, 0, 20000));
		send_transaction(make_item(MODE_UNUSED, 1'b1, -1, -1));
		send_transaction(make_item(MODE_TICK, 1'b0, -32768, -32768));
		wait_for_drain();
	endtask

	task automatic test_status_thresholds();
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: begin
					write_register(CFG_OPEN_THRESHOLD, 16'h8000);
					write_register(CFG_CLOSED_THRESHOLD, 16'h7fff);
				end
				1: begin
					write_register(CFG_OPEN_THRESHOLD, 16'h7fff);
					write_register(CFG_CLOSED_THRESHOLD, 16'h8000);
				end
				default: begin
					write_register(CFG_OPEN_THRESHOLD, 16'($urandom));
					write_register(CFG_CLOSED_THRESHOLD, 16'($urandom));
				end
			endcase
			set_idling(k);
			run_random(40, 1'b0, 2'b00);
		end
	endtask

	task automatic test_scan_sequence();
		set_idling(0);
		write_register(CFG_OPEN_THRESHOLD, 16'h8000);
		write_register(CFG_FIRE_TICKS, 16'd0);
		write_register(CFG_CHARGE_TICKS, 16'd0);
		send_transaction(make_item(MODE_IGNITE, 1'b0, 0, 0));
		send_transaction(make_item(MODE_IGNITE, 1'b1, 0, 0));
		send_transaction(make_item(MODE_QUERY, 1'b1, -32768, -32768));
		send_transaction(make_item(MODE_TICK, 1'b0, -32768, 5));
		send_transaction(make_item(MODE_TICK, 1'b1, 7, -32768));
		send_transaction(make_item(MODE_TICK, 1'b0, 0, 0));
		wait_for_drain();
		write_register(CFG_FIRE_TICKS, 16'd2);
		write_register(CFG_CHARGE_TICKS, 16'd1);
		send_transaction(make_item(MODE_IGNITE, 1'b1, 0, 0));
		repeat (6) send_transaction(make_item(MODE_TICK, 1'b0, 32767, 32767));
		wait_for_drain();
	endtask

	task automatic test_mid_phase_change();
		set_idling(3);
		write_register(CFG_FIRE_TICKS, 16'hffff);
		write_register(CFG_CHARGE_TICKS, 16'hffff);
		send_transaction(make_item(MODE_IGNITE, 1'b0, 0, 0));
		send_transaction(make_item(MODE_QUERY, 1'b0, -32768, 0));
		repeat (2) send_transaction(make_item(MODE_TICK, 1'b0, 1000, 1000));
		wait_for_drain();
		write_register(CFG_FIRE_TICKS, 16'd1);
		send_transaction(make_item(MODE_TICK, 1'b0, 1000, 1000));
		wait_for_drain();
		write_register(CFG_CHARGE_TICKS, 16'd1);
		send_transaction(make_item(MODE_TICK, 1'b1, -1, 1000));
		wait_for_drain();
	endtask

	task automatic test_retry_scans();
		for (int k = 0; k < 4; k++) begin
			write_register(CFG_OPEN_THRESHOLD, 16'($urandom));
			write_register(CFG_CLOSED_THRESHOLD, 16'($urandom));
			write_register(CFG_FIRE_TICKS, 16'($urandom_range(6)));
			write_register(CFG_CHARGE_TICKS, 16'($urandom_range(6)));
			set_idling(k);
			if (k == 0)
				hold_cycles = 300;
			run_random(120, 1'b1, 2'b00);
		end
	endtask

	task automatic test_confirm_fire(logic [1:0] fire_mask, int idling, int count);
		write_register(CFG_OPEN_THRESHOLD, 16'(int'($urandom_range(4000)) - 2000));
		write_register(CFG_FIRE_TICKS, 16'($urandom_range(4, 1)));
		write_register(CFG_CHARGE_TICKS, 16'($urandom_range(4)));
		set_idling(idling);
		run_random(count, 1'b1, fire_mask);
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_OPEN_THRESHOLD;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_queries();
		test_status_thresholds();
		test_scan_sequence();
		test_mid_phase_change();
		test_retry_scans();
		test_confirm_fire(2'b01, 3, 150);
		test_confirm_fire(2'b11, 2, 150);
		test_confirm_fire(2'b11, 1, 100);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
src/difs_pkg.sv
src/difs_core.sv
src/dual_igniter_fire_sequencer.sv
dv/dual_igniter_fire_sequencer_tb.sv
